// ===== rtl/fawd_pkg.sv =====
// Package: shared types, constants and record codes of the readout word decoder.
`timescale 1ns / 1ps
package fawd_pkg;

  localparam int unsigned MaxEventsDefault = 200;

  // record kinds
  localparam logic [3:0] KindTrigTime = 4'd0;
  localparam logic [3:0] KindWinSum   = 4'd1;
  localparam logic [3:0] KindIntegral = 4'd2;
  localparam logic [3:0] KindPTime    = 4'd3;
  localparam logic [3:0] KindPulse    = 4'd4;
  localparam logic [3:0] KindPedestal = 4'd5;
  localparam logic [3:0] KindWinHead  = 4'd6;
  localparam logic [3:0] KindSamples  = 4'd7;
  localparam logic [3:0] KindError    = 4'd8;
  localparam logic [3:0] KindQuiet    = 4'd9;
  localparam logic [3:0] KindTooMany  = 4'd10;

  // readout data types (bits 30..27 of a type word)
  localparam logic [3:0] DtBlockHead = 4'd0;
  localparam logic [3:0] DtBlockTail = 4'd1;
  localparam logic [3:0] DtEventHead = 4'd2;
  localparam logic [3:0] DtTrigTime  = 4'd3;
  localparam logic [3:0] DtWinRaw    = 4'd4;
  localparam logic [3:0] DtWinSum    = 4'd5;
  localparam logic [3:0] DtPulseRaw  = 4'd6;
  localparam logic [3:0] DtIntegral  = 4'd7;
  localparam logic [3:0] DtPTime     = 4'd8;
  localparam logic [3:0] DtPulseData = 4'd9;
  localparam logic [3:0] DtPedestal  = 4'd10;
  localparam logic [3:0] DtBad11     = 4'd11;
  localparam logic [3:0] DtBad12     = 4'd12;
  localparam logic [3:0] DtFill13    = 4'd13;
  localparam logic [3:0] DtFill14    = 4'd14;
  localparam logic [3:0] DtFill15    = 4'd15;

  // register indexes
  localparam logic [0:0] RegEvents = 1'd0;
  localparam logic [0:0] RegFirst  = 1'd1;

  typedef struct packed {
    logic [31:0] word;
    logic [11:0] rocid;
    logic        last_in_bank;
  } in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [11:0] crate_id;
    logic [7:0]  event_index;
    logic [4:0]  slot;
    logic [3:0]  channel;
    logic [21:0] trigger_number;
    logic [7:0]  pulse_num;
    logic [47:0] value_a;
    logic [13:0] value_b;
    logic [14:0] value_c;
    logic [8:0]  value_d;
    logic [11:0] flags;
  } rec_t;

  // configuration seen by the decoder
  typedef struct packed {
    logic [7:0] nevents;
    logic [7:0] first_index;
  } cfg_t;

endpackage

// ===== rtl/fawd_if.sv =====
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface fawd_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fawd_cfg.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module fawd_cfg #(
  parameter int unsigned MaxEvents = fawd_pkg::MaxEventsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fawd_pkg::cfg_t     cfg_o
);
  logic [7:0] events_q, first_q;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      events_q <= 8'd1;
      first_q  <= 8'd0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == fawd_pkg::RegEvents) events_q <= pwdata[7:0];
      else first_q <= pwdata[7:0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == fawd_pkg::RegEvents) prdata = {24'd0, events_q};
      else prdata = {24'd0, first_q};
    end
  end

  // event count capped at the maximum
  assign cfg_o.nevents = (events_q < 8'(MaxEvents)) ? events_q : 8'(MaxEvents);
  assign cfg_o.first_index = first_q;
endmodule

// ===== rtl/fawd_core.sv =====
// Decoder core: bank state and record formation, one word per cycle while step_i is high.
`timescale 1ns / 1ps
module fawd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  fawd_pkg::in_t  in_i,
  input  fawd_pkg::cfg_t cfg_i,
  output logic [1:0]     nrec_o,
  output fawd_pkg::rec_t rec0_o,
  output fawd_pkg::rec_t rec1_o
);
  typedef enum logic [2:0] {
    ModeType, ModeTrig, ModeWin, ModePd2, ModePd3, ModeHold
  } mode_e;

  typedef struct packed {
    logic [3:0]  channel;
    logic        qfped;
    logic [13:0] pedestal;
    logic [7:0]  count;
    logic [17:0] integral;
    logic [2:0]  w2flags;
    logic [8:0]  nsamp;
  } pctx_t;

  // marks a type word that makes no record
  localparam logic [3:0] KindNone = 4'hF;

  mode_e       mode_q, mode_d;
  logic [4:0]  slot_q, slot_d;
  logic [21:0] trig_q, trig_d;
  logic [7:0]  ptr_q, ptr_d, cur_q, cur_d;
  logic        ev_q, ev_d, tol_q, tol_d, dead_q, dead_d, pv_q, pv_d;
  logic [11:0] left_q, left_d;
  logic [3:0]  wch_q, wch_d;
  fawd_pkg::rec_t pend_q, pend_d;
  pctx_t       pc_q, pc_d;
  logic [31:0] skip_q, skip_d;

  logic [31:0] w;
  logic        last;
  logic [1:0]  n;
  fawd_pkg::rec_t o0, o1;

  // bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeType;
      slot_q <= '0; trig_q <= '1; ptr_q <= 8'd0; cur_q <= '0;
      ev_q <= 1'b0; tol_q <= 1'b0; dead_q <= 1'b0; pv_q <= 1'b0;
      left_q <= '0; wch_q <= '0; pc_q <= '0; skip_q <= '0; pend_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; slot_q <= slot_d; trig_q <= trig_d; ptr_q <= ptr_d;
      cur_q <= cur_d; ev_q <= ev_d; tol_q <= tol_d; dead_q <= dead_d;
      pv_q <= pv_d; left_q <= left_d; wch_q <= wch_d; pc_q <= pc_d;
      skip_q <= skip_d; pend_q <= pend_d;
    end
  end

  assign w = in_i.word;
  assign last = in_i.last_in_bank;

  always_comb begin
    logic [3:0] ch;
    logic [7:0] ev;
    logic       type_go;
    logic       inv1, inv2, wlast, cnt2;
    logic [12:0] s1, s2;
    fawd_pkg::rec_t b, r;
    mode_d = mode_q; slot_d = slot_q; trig_d = trig_q; ptr_d = ptr_q;
    cur_d = cur_q; ev_d = ev_q; tol_d = tol_q; dead_d = dead_q;
    pv_d = pv_q; left_d = left_q; wch_d = wch_q; pend_d = pend_q;
    pc_d = pc_q; skip_d = skip_q;
    n = 2'd0; o0 = '0; o1 = '0; type_go = 1'b0; r = '0; b = '0;
    ch = w[26:23];
    ev = w[26:19];
    inv1 = w[29]; inv2 = w[13];
    s1 = inv1 ? 13'd0 : w[28:16];
    s2 = inv2 ? 13'd0 : w[12:0];
    wlast = left_q <= 12'd2;
    cnt2 = !(left_q == 12'd2 && inv2);

    if (!dead_q) begin
      case (mode_q)
        ModeTrig: begin
          mode_d = ModeType;
          pv_d = 1'b0;
          r = pend_q;
          if (!w[31]) r.value_a = pend_q.value_a + {w[23:0], 24'd0};
          else type_go = 1'b1;
          if (pv_q) begin
            o0 = r; n = 2'd1;
          end
        end
        ModeWin: begin
          if (w[31]) begin
            mode_d = ModeType; type_go = 1'b1;
          end else begin
            r = '0;
            r.kind = fawd_pkg::KindSamples; r.crate_id = in_i.rocid;
            r.event_index = cur_q; r.slot = slot_q; r.channel = wch_q;
            r.trigger_number = trig_q;
            r.value_a = {35'd0, s1}; r.value_b = {1'b0, s2};
            r.value_d = cnt2 ? 9'd2 : 9'd1;
            r.flags = {7'd0, wlast, cnt2 & s2[12], s1[12], cnt2 & inv2, inv1};
            o0 = r; n = 2'd1;
            if (wlast) begin
              left_d = '0; mode_d = ModeType;
            end else left_d = left_q - 12'd2;
          end
        end
        ModePd2: type_go = 1'b0;
        ModePd3: type_go = 1'b0;
        ModeHold: begin
          pv_d = 1'b0;
          if (w == skip_q) begin
            tol_d = 1'b1; mode_d = ModeType;
          end else begin
            o0 = pend_q; n = 2'd1;
            if (pc_q.count != 8'd255) pc_d.count = pc_q.count + 8'd1;
            mode_d = ModePd2;
          end
        end
        default: type_go = 1'b1;
      endcase

      // second pulse word (also after a held pulse)
      if (mode_q == ModePd2 || (mode_q == ModeHold && w != skip_q)) begin
        if (w[31]) begin
          mode_d = ModeType; type_go = 1'b1;
        end else if (w[30] != 1'b1) begin
          r = '0;
          r.kind = tol_q ? fawd_pkg::KindQuiet : fawd_pkg::KindError;
          r.crate_id = in_i.rocid; r.event_index = cur_q; r.slot = slot_q;
          r.trigger_number = trig_q; r.value_a = {16'd0, w};
          if (n == 2'd0) o0 = r; else o1 = r;
          n = n + 2'd1; dead_d = 1'b1; mode_d = ModeType;
        end else begin
          pc_d.integral = w[29:12]; pc_d.w2flags = w[11:9];
          pc_d.nsamp = w[8:0]; mode_d = ModePd3;
        end
      end

      // third pulse word
      if (mode_q == ModePd3) begin
        r = '0;
        r.crate_id = in_i.rocid; r.event_index = cur_q; r.slot = slot_q;
        r.trigger_number = trig_q;
        if (w[31:30] != 2'b00) begin
          r.kind = tol_q ? fawd_pkg::KindQuiet : fawd_pkg::KindError;
          r.value_a = {16'd0, w};
          o0 = r; n = 2'd1; dead_d = 1'b1; mode_d = ModeType;
        end else begin
          r.kind = fawd_pkg::KindPulse; r.channel = pc_q.channel;
          r.pulse_num = pc_q.count;
          r.value_a = {18'd0, w[14:3], pc_q.integral};
          r.value_b = pc_q.pedestal;
          r.value_c = {w[29:21], w[20:15]};
          r.value_d = pc_q.nsamp;
          r.flags = {5'd0, w[2:0], pc_q.w2flags[0], pc_q.w2flags[1],
                     pc_q.w2flags[2], pc_q.qfped};
          if (pc_q.integral == 18'd0 && !last) begin
            pend_d = r; pv_d = 1'b1; skip_d = w; mode_d = ModeHold;
          end else begin
            o0 = r; n = 2'd1;
            if (pc_q.count != 8'd255) pc_d.count = pc_q.count + 8'd1;
            mode_d = ModePd2;
          end
        end
      end

      // type word decode
      if (type_go && w[31]) begin
        b.crate_id = in_i.rocid; b.event_index = cur_q; b.slot = slot_q;
        b.trigger_number = trig_q; b.channel = ch;
        r = '0;
        case (w[30:27])
          fawd_pkg::DtBlockHead: slot_d = w[26:22];
          fawd_pkg::DtBlockTail: ev_d = 1'b0;
          fawd_pkg::DtEventHead: begin
            trig_d = w[21:0];
            if (ptr_q >= cfg_i.nevents) begin
              r = b; r.trigger_number = w[21:0]; r.channel = '0;
              r.kind = fawd_pkg::KindTooMany; r.value_a = {16'd0, w};
              dead_d = 1'b1; mode_d = ModeType;
            end else begin
              cur_d = ptr_q; ptr_d = ptr_q + 8'd1; ev_d = 1'b1;
            end
          end
          fawd_pkg::DtTrigTime: begin
            r = b; r.channel = '0; r.kind = fawd_pkg::KindTrigTime;
            r.value_a = {24'd0, w[23:0]};
            if (last) begin
              if (!ev_q) r.kind = KindNone;
            end else begin
              pend_d = r; pv_d = ev_q; mode_d = ModeTrig;
              r.kind = KindNone;
            end
          end
          fawd_pkg::DtWinRaw: if (ev_q) begin
            r = b; r.kind = fawd_pkg::KindWinHead; r.value_a = {36'd0, w[11:0]};
            wch_d = ch; left_d = w[11:0];
            if (w[11:0] != 12'd0) mode_d = ModeWin;
          end else r.kind = KindNone;
          fawd_pkg::DtWinSum: if (ev_q) begin
            r = b; r.kind = fawd_pkg::KindWinSum;
            r.value_a = {26'd0, w[21:0]}; r.flags = {11'd0, w[22]};
          end else r.kind = KindNone;
          fawd_pkg::DtIntegral, fawd_pkg::DtPTime: if (ev_q) begin
            r = b;
            r.kind = (w[30:27] == fawd_pkg::DtIntegral) ? fawd_pkg::KindIntegral
                                                        : fawd_pkg::KindPTime;
            r.pulse_num = {6'd0, w[22:21]}; r.flags = {10'd0, w[20:19]};
            r.value_a = {29'd0, w[18:0]};
          end else r.kind = KindNone;
          fawd_pkg::DtPulseData: begin
            if (ev == 8'd0 || ev > cfg_i.nevents) begin
              r = b; r.channel = '0; r.kind = fawd_pkg::KindError;
              r.value_a = {16'd0, w}; dead_d = 1'b1; mode_d = ModeType;
            end else begin
              cur_d = ev - 8'd1; ev_d = 1'b1; trig_d = {14'd0, ev};
              pc_d = '0; pc_d.channel = w[18:15]; pc_d.qfped = w[14];
              pc_d.pedestal = w[13:0]; mode_d = ModePd2;
            end
            if (!dead_d) r.kind = KindNone;
          end
          fawd_pkg::DtPedestal: if (ev_q) begin
            r = b; r.kind = fawd_pkg::KindPedestal;
            r.pulse_num = {6'd0, w[22:21]};
            r.value_a = {39'd0, w[20:12]}; r.value_b = {2'd0, w[11:0]};
          end else r.kind = KindNone;
          fawd_pkg::DtBad11, fawd_pkg::DtBad12: begin
            r = b; r.channel = '0;
            r.kind = tol_q ? fawd_pkg::KindQuiet : fawd_pkg::KindError;
            r.value_a = {16'd0, w}; dead_d = 1'b1; mode_d = ModeType;
          end
          default: r.kind = KindNone;
        endcase
        if (w[30:27] == fawd_pkg::DtBlockHead || w[30:27] == fawd_pkg::DtBlockTail)
          r.kind = KindNone;
        if (w[30:27] == fawd_pkg::DtEventHead && !dead_d) r.kind = KindNone;
        if (r.kind != KindNone) begin
          if (n == 2'd0) o0 = r; else o1 = r;
          n = n + 2'd1;
        end
      end
    end

    // end of bank: back to the start state
    if (last) begin
      mode_d = ModeType; slot_d = '0; trig_d = '1;
      ptr_d = cfg_i.first_index; cur_d = '0; ev_d = 1'b0; tol_d = 1'b0;
      dead_d = 1'b0; pv_d = 1'b0; left_d = '0; wch_d = '0; pc_d = '0;
      skip_d = '0;
    end
  end

  assign nrec_o = n;
  assign rec0_o = o0;
  assign rec1_o = o1;

  // reset sets ptr to 0; it takes the first index at the end of each bank
endmodule

// ===== rtl/fawd_outq.sv =====
// Output queue: holds up to four records, delivers one per cycle while the receiver is ready.
`timescale 1ns / 1ps
module fawd_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [1:0]     n_i,
  input  fawd_pkg::rec_t r0_i,
  input  fawd_pkg::rec_t r1_i,
  output logic           room_o,
  fawd_if.source         out
);
  fawd_pkg::rec_t q_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop = out.valid && out.ready;
  assign out.valid = cnt_q != 3'd0;
  assign out.data = q_q[rd_q];
  assign room_o = cnt_q <= 3'd2 || (cnt_q == 3'd3 && 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      rd_q <= rd_q + {1'b0, pop};
      if (push_i) wr_q <= wr_q + n_i;
      cnt_q <= cnt_q + (push_i ? {1'b0, n_i} : 3'd0) - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && n_i != 2'd0) q_q[wr_q] <= r0_i;
    if (push_i && n_i == 2'd2) q_q[wr_q + 2'd1] <= r1_i;
  end
endmodule

// ===== rtl/flash_adc_readout_word_decoder_top.sv =====
// Top level: flash-ADC readout word decoder.
//  channel   dir  payload                   request
//  in_ch     in   word, rocid, last_in_bank one readout word
//  out_ch    out  record fields             one record
//  apb       in   two 8-bit registers       register write
// One word is taken per cycle while the queue has room; records leave one
// per cycle from a four-entry queue while out_ch is ready, so a word making
// two records fills two entries. Input is held off only while the queue has
// fewer than two free entries. Reset (rst_ni low) clears the bank state and
// the queue; registers return to one event per block and first index zero.
`timescale 1ns / 1ps
module flash_adc_readout_word_decoder_top #(
  parameter int unsigned MaxEvents = fawd_pkg::MaxEventsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fawd_if.sink        in_ch,
  fawd_if.source      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  fawd_pkg::cfg_t cfg;
  fawd_pkg::rec_t r0, r1;
  logic [1:0] n;
  logic room, step;

  fawd_cfg #(.MaxEvents(MaxEvents)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  assign in_ch.ready = room;
  assign step = in_ch.valid && room;

  fawd_core u_core (
    .clk_i, .rst_ni, .step_i(step), .in_i(in_ch.data), .cfg_i(cfg),
    .nrec_o(n), .rec0_o(r0), .rec1_o(r1)
  );

  fawd_outq u_q (
    .clk_i, .rst_ni, .push_i(step), .n_i(n), .r0_i(r0), .r1_i(r1),
    .room_o(room), .out(out_ch)
  );

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.data.kind <= fawd_pkg::KindTooMany) else $error("bad kind");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> n != 2'd3) else $error("record count");
  a_pready: assert property (@(posedge clk_i) pready) else $error("pready");
endmodule
